FILE: design/pcps_pkg.sv
// Shared types and constants for the piecewise CDF position sampler.
// No dependencies.
package pcps_pkg;

    localparam int MAX_RECORDS = 1024;
    localparam int COUNT_DEPTH = 10;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int EVT_W   = 4;
    localparam int STS_W   = 2;

    localparam int REC_AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_AW  = (COUNT_DEPTH > 1) ? $clog2(COUNT_DEPTH) : 1;
    localparam int REC_CW  = $clog2(MAX_RECORDS + 1);
    localparam int CNT_CW  = $clog2(COUNT_DEPTH + 1);
    localparam int SRCH_W  = (REC_CW > CNT_CW) ? REC_CW : CNT_CW;
    localparam int EVT_MAX = (1 << EVT_W) - 1;

    localparam logic [CFG_W-1:0] RECORD_COUNT_RST = CFG_W'(2);

    localparam logic [MODE_W-1:0] MODE_LOAD_REC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_CNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMP_POS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SAMP_CNT = 2'd3;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_OUTSIDE = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_RD,
        ST_CMP,
        ST_PREV,
        ST_CUR,
        ST_CAPT,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_mid;
        logic step;
        logic rd_prev;
        logic rd_cur;
        logic cap_prev;
        logic cap_cur;
        logic mul;
        logic fin;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic sel_cnt;
        logic hit_bad;
        logic span_bad;
        logic out_free;
    } t_sts;

endpackage

FILE: design/pcps_if.sv
// Valid/ready channel interfaces for sampler items and results.
// Depends on pcps_pkg.
interface pcps_in_if import pcps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [IDX_W-1:0]    entry_index;
    logic [DATA_W-1:0]   load_position;
    logic [DATA_W-1:0]   load_value;
    logic [DATA_W-1:0]   roll;
    logic [DATA_W-1:0]   pick;

    modport source (output valid, mode, entry_index, load_position, load_value, roll, pick,
                    input ready);
    modport sink   (input valid, mode, entry_index, load_position, load_value, roll, pick,
                    output ready);
endinterface

interface pcps_out_if import pcps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   sampled_position;
    logic [EVT_W-1:0]    event_count;
    logic [STS_W-1:0]    status;

    modport source (output valid, sampled_position, event_count, status, input ready);
    modport sink   (input valid, sampled_position, event_count, status, output ready);
endinterface

FILE: design/piecewise_cdf_position_sampler_unit.sv
// Piecewise CDF position sampler: table loads, lower-bound search, interval pick.
// Loads are written as they are accepted. A search step is check, read, compare; a position
// sample then reads the two bracketing positions, multiplies and adds unless out of range or empty,
// a count sample ends with the search; each result then goes to the output register. One item at a time.
// A result waits in the output register while the next item is taken.
// Reset (sync, active low) clears the FSM, output valid and record_count (to 2); tables are not.
module piecewise_cdf_position_sampler_unit import pcps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcps_in_if.sink             i_in,
    pcps_out_if.source          o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = in_ready;

    pcps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_sample (i_in.mode[1]),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    pcps_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_in.mode),
        .i_entry_index      (i_in.entry_index),
        .i_load_position    (i_in.load_position),
        .i_load_value       (i_in.load_value),
        .i_roll             (i_in.roll),
        .i_pick             (i_in.pick),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_sampled_position (o_out.sampled_position),
        .o_event_count      (o_out.event_count),
        .o_status           (o_out.status)
    );

endmodule

FILE: design/pcps_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pcps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pcps_ctrl.sv
// Sequencing FSM: binary search steps, interval reads, multiply, result push.
// Depends on pcps_pkg.
module pcps_ctrl import pcps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_sample,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_sample) begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (!i_sts.len_zero) begin
                    n_state = ST_RD;
                end else if (i_sts.sel_cnt || i_sts.hit_bad) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_PREV;
                end
            end
            ST_RD: begin
                o_cmd.rd_mid = 1'b1;
                n_state      = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_CHK;
            end
            ST_PREV: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = ST_CUR;
            end
            ST_CUR: begin
                o_cmd.rd_cur   = 1'b1;
                o_cmd.cap_prev = 1'b1;
                n_state        = ST_CAPT;
            end
            ST_CAPT: begin
                o_cmd.cap_cur = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                if (i_sts.span_bad) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pcps_dp.sv
// Datapath: record RAMs, count table, search registers, multiply, output register.
// Depends on pcps_pkg and pcps_ram.
module pcps_dp import pcps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [DATA_W-1:0]   i_load_position,
    input  logic [DATA_W-1:0]   i_load_value,
    input  logic [DATA_W-1:0]   i_roll,
    input  logic [DATA_W-1:0]   i_pick,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_sampled_position,
    output logic [EVT_W-1:0]    o_event_count,
    output logic [STS_W-1:0]    o_status
);

    logic [CFG_W-1:0]    r_rec_cnt;
    logic [SRCH_W-1:0]   r_n;
    logic [SRCH_W-1:0]   r_lo;
    logic [SRCH_W-1:0]   r_len;
    logic                r_sel_cnt;
    logic [DATA_W-1:0]   r_roll;
    logic [DATA_W-1:0]   r_pick;
    logic [DATA_W-1:0]   r_cnt_tab [COUNT_DEPTH];
    logic [DATA_W-1:0]   r_cnt_q;
    logic [DATA_W-1:0]   r_prev;
    logic [DATA_W-1:0]   r_cur;
    logic [2*DATA_W-1:0] r_prod;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_res_pos;
    logic [EVT_W-1:0]    r_res_cnt;
    logic [STS_W-1:0]    r_res_st;
    logic [DATA_W-1:0]   r_out_pos;
    logic [EVT_W-1:0]    r_out_cnt;
    logic [STS_W-1:0]    r_out_st;

    logic [SRCH_W-1:0]   half;
    logic [SRCH_W-1:0]   mid;
    logic [SRCH_W-1:0]   n_clamp;
    logic [DATA_W-1:0]   map_q;
    logic [DATA_W-1:0]   pos_q;
    logic [DATA_W-1:0]   probe;
    logic                lt;
    logic                rec_we;
    logic [REC_AW-1:0]   map_addr;
    logic [REC_AW-1:0]   pos_addr;
    logic                hit_bad;
    logic                span_bad;

    assign half     = r_len >> 1;
    assign mid      = r_lo + half;
    assign probe    = r_sel_cnt ? r_cnt_q : map_q;
    assign lt       = probe < r_roll;
    assign hit_bad  = (r_lo == '0) || (r_lo >= r_n);
    assign span_bad = r_cur <= r_prev;
    assign n_clamp  = (32'(r_rec_cnt) > 32'(MAX_RECORDS)) ? SRCH_W'(MAX_RECORDS)
                                                           : SRCH_W'(r_rec_cnt);

    assign rec_we   = i_cmd.accept && (i_mode == MODE_LOAD_REC)
                      && (32'(i_entry_index) < 32'(MAX_RECORDS));
    assign map_addr = i_cmd.accept ? REC_AW'(i_entry_index) : mid[REC_AW-1:0];
    assign pos_addr = i_cmd.accept  ? REC_AW'(i_entry_index) :
                      i_cmd.rd_prev ? REC_AW'(r_lo - SRCH_W'(1)) : r_lo[REC_AW-1:0];

    pcps_ram #(.WIDTH(DATA_W), .DEPTH(MAX_RECORDS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_addr  (map_addr),
        .i_wdata (i_load_value),
        .o_rdata (map_q)
    );

    pcps_ram #(.WIDTH(DATA_W), .DEPTH(MAX_RECORDS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_addr  (pos_addr),
        .i_wdata (i_load_position),
        .o_rdata (pos_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt   <= RECORD_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_cnt <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel_cnt <= (i_mode == MODE_SAMP_CNT);
            r_roll    <= i_roll;
            r_pick    <= i_pick;
            r_n       <= n_clamp;
            r_lo      <= '0;
            r_len     <= (i_mode == MODE_SAMP_CNT) ? SRCH_W'(COUNT_DEPTH) : n_clamp;
            if ((i_mode == MODE_LOAD_CNT) && (32'(i_entry_index) < 32'(COUNT_DEPTH))) begin
                r_cnt_tab[CNT_AW'(i_entry_index)] <= i_load_value;
            end
        end
        if (i_cmd.rd_mid) begin
            r_cnt_q <= r_cnt_tab[mid[CNT_AW-1:0]];
        end
        if (i_cmd.step) begin
            if (lt) begin
                r_lo  <= mid + SRCH_W'(1);
                r_len <= r_len - half - SRCH_W'(1);
            end else begin
                r_len <= half;
            end
        end
        if (i_cmd.cap_prev) begin
            r_prev <= pos_q;
        end
        if (i_cmd.cap_cur) begin
            r_cur <= pos_q;
        end
        if (i_cmd.mul) begin
            r_prod <= {{DATA_W{1'b0}}, r_pick} * {{DATA_W{1'b0}}, r_cur - r_prev};
        end
        if (i_cmd.fin) begin
            r_res_pos <= '0;
            r_res_cnt <= '0;
            r_res_st  <= STS_OK;
            if (r_sel_cnt) begin
                r_res_cnt <= (32'(r_lo) > 32'(EVT_MAX)) ? EVT_W'(EVT_MAX) : EVT_W'(r_lo);
            end else if (hit_bad) begin
                r_res_st <= STS_OUTSIDE;
            end else if (span_bad) begin
                r_res_st <= STS_EMPTY;
            end else begin
                r_res_pos <= r_prev + r_prod[2*DATA_W-1:DATA_W];
            end
        end
        if (i_cmd.push) begin
            r_out_pos <= r_res_pos;
            r_out_cnt <= r_res_cnt;
            r_out_st  <= r_res_st;
        end
    end

    always_comb begin
        o_sts.len_zero = (r_len == '0);
        o_sts.sel_cnt  = r_sel_cnt;
        o_sts.hit_bad  = hit_bad;
        o_sts.span_bad = span_bad;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid        = r_out_valid;
    assign o_sampled_position = r_out_pos;
    assign o_event_count      = r_out_cnt;
    assign o_status           = r_out_st;

endmodule

FILE: verif/pcps_sample_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the piecewise CDF position sampler: mirrors both tables and record_count
// from the observed beats, predicts each sample result and compares result beats in order.
// Depends on pcps_pkg and the channel interfaces in pcps_if.
module pcps_sample_checker import pcps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pcps_in_if               i_item,
    pcps_out_if              i_res,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic [EVT_W-1:0]  evt_count;
        logic [STS_W-1:0]  status;
    } t_sample;

    logic [DATA_W-1:0] rec_pos [MAX_RECORDS];
    logic [DATA_W-1:0] rec_map [MAX_RECORDS];
    logic [DATA_W-1:0] cnt_cdf [COUNT_DEPTH];
    logic [CFG_W-1:0]  rec_count;
    t_sample           expected_samples [$];
    t_sample           want_beat;
    int unsigned       fail_n;

    assign o_fail_count = fail_n;

    initial begin
        fail_n    = 0;
        o_pending = 0;
        rec_count = RECORD_COUNT_RST;
        for (int i = 0; i < MAX_RECORDS; i++) begin
            rec_pos[i] = '0;
            rec_map[i] = '0;
        end
        for (int i = 0; i < COUNT_DEPTH; i++) begin
            cnt_cdf[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] sampler mismatch: %s", $time, msg);
        fail_n++;
    endtask

    // lower bound: first index whose value is >= key, n if none
    function automatic int unsigned first_at_least(input bit in_counts,
                                                   input logic [DATA_W-1:0] key,
                                                   input int unsigned n);
        int unsigned       lo;
        int unsigned       len;
        int unsigned       half;
        int unsigned       mid;
        logic [DATA_W-1:0] probe;
        lo  = 0;
        len = n;
        while (len > 0) begin
            half = len / 2;
            mid  = lo + half;
            if (in_counts) begin
                probe = cnt_cdf[mid];
            end else begin
                probe = rec_map[mid];
            end
            if (probe < key) begin
                lo  = mid + 1;
                len = len - half - 1;
            end else begin
                len = half;
            end
        end
        return lo;
    endfunction

    function automatic t_sample predict_sample(input logic [MODE_W-1:0] mode,
                                               input logic [DATA_W-1:0] roll,
                                               input logic [DATA_W-1:0] pick);
        t_sample             r;
        int unsigned         n;
        int unsigned         hit;
        logic [DATA_W-1:0]   prev;
        logic [DATA_W-1:0]   cur;
        logic [DATA_W-1:0]   span;
        logic [2*DATA_W-1:0] prod;
        r = '0;
        if (mode == MODE_SAMP_POS) begin
            n = rec_count;
            if (n > MAX_RECORDS) begin
                n = MAX_RECORDS;
            end
            hit = first_at_least(1'b0, roll, n);
            if (hit == 0 || hit >= n) begin
                r.status = STS_OUTSIDE;
            end else begin
                prev = rec_pos[hit-1];
                cur  = rec_pos[hit];
                if (cur <= prev) begin
                    r.status = STS_EMPTY;
                end else begin
                    span = cur - prev;
                    prod = {{DATA_W{1'b0}}, pick} * {{DATA_W{1'b0}}, span};
                    r.position = prev + prod[2*DATA_W-1:DATA_W];
                    r.status   = STS_OK;
                end
            end
        end else begin
            hit = first_at_least(1'b1, roll, COUNT_DEPTH);
            if (hit > EVT_MAX) begin
                r.evt_count = EVT_W'(EVT_MAX);
            end else begin
                r.evt_count = EVT_W'(hit);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_count = RECORD_COUNT_RST;
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rec_count = i_cfg_data;
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending: pos=%h cnt=%0d sts=%0d",
                                              i_res.sampled_position, i_res.event_count,
                                              i_res.status));
                end else begin
                    want_beat = expected_samples.pop_front();
                    if (i_res.sampled_position !== want_beat.position) begin
                        report_mismatch($sformatf("sampled_position got %h want %h",
                                                  i_res.sampled_position, want_beat.position));
                    end
                    if (i_res.event_count !== want_beat.evt_count) begin
                        report_mismatch($sformatf("event_count got %0d want %0d",
                                                  i_res.event_count, want_beat.evt_count));
                    end
                    if (i_res.status !== want_beat.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_res.status, want_beat.status));
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                case (i_item.mode)
                    MODE_LOAD_REC: begin
                        if (int'(i_item.entry_index) < MAX_RECORDS) begin
                            rec_pos[i_item.entry_index] = i_item.load_position;
                            rec_map[i_item.entry_index] = i_item.load_value;
                        end
                    end
                    MODE_LOAD_CNT: begin
                        if (int'(i_item.entry_index) < COUNT_DEPTH) begin
                            cnt_cdf[i_item.entry_index] = i_item.load_value;
                        end
                    end
                    default: begin
                        expected_samples.insert(expected_samples.size(),
                                                predict_sample(i_item.mode, i_item.roll,
                                                               i_item.pick));
                    end
                endcase
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

FILE: verif/piecewise_cdf_position_sampler_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for piecewise_cdf_position_sampler_unit: loads tables, drives directed and
// random sample beats with random idling and back-pressure. Depends on pcps_pkg, pcps_if
// and pcps_sample_checker.
module piecewise_cdf_position_sampler_unit_test;
    import pcps_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;   // covers a full-depth search
    localparam int TAIL_CYCLES   = 100;
    localparam int IDLE_PCT      = 19;
    localparam int ITEM_TARGET   = 800;
    localparam int LOAD_SPAN     = 64;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int unsigned      fail_count;
    int unsigned      pending;
    logic             steady;
    int unsigned      hold_seq;
    int unsigned      items_sent;

    logic [DATA_W-1:0] map_shadow [MAX_RECORDS];
    logic [DATA_W-1:0] cnt_shadow [COUNT_DEPTH];

    pcps_in_if  item_ch ();
    pcps_out_if res_ch ();

    piecewise_cdf_position_sampler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (item_ch),
        .o_out       (res_ch),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    pcps_sample_checker sample_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_res        (res_ch),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result sink: random stalls, plus one long hold-off each time hold_seq changes
    initial begin : result_sink
        int unsigned hold_seen;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] lpos, input logic [DATA_W-1:0] lval,
                             input logic [DATA_W-1:0] roll, input logic [DATA_W-1:0] pick);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.mode          <= mode;
        item_ch.entry_index   <= idx;
        item_ch.load_position <= lpos;
        item_ch.load_value    <= lval;
        item_ch.roll          <= roll;
        item_ch.pick          <= pick;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic load_record(input int unsigned idx, input logic [DATA_W-1:0] pos,
                               input logic [DATA_W-1:0] map);
        send_item(MODE_LOAD_REC, IDX_W'(idx), pos, map, $urandom, $urandom);
        map_shadow[idx] = map;
    endtask

    // wide first span, equal and falling positions, full-scale last record
    task automatic load_default(input int unsigned idx);
        case (idx)
            0:               load_record(idx, 32'h0000_0000, 32'h0001_0000);
            1:               load_record(idx, 32'hFFFF_FFFF, 32'h0002_0000);
            2:               load_record(idx, 32'hFFFF_FFFF, 32'h0003_0000);
            3:               load_record(idx, 32'h0000_0100, 32'h0003_8000);
            MAX_RECORDS - 1: load_record(idx, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            default:         load_record(idx, DATA_W'(idx) * 32'h1000,
                                         DATA_W'(idx) * 32'h1_0000);
        endcase
    endtask

    task automatic load_count(input int unsigned idx, input logic [DATA_W-1:0] value);
        send_item(MODE_LOAD_CNT, IDX_W'(idx), $urandom, value, $urandom, $urandom);
        if (idx < COUNT_DEPTH) begin
            cnt_shadow[idx] = value;
        end
    endtask

    task automatic sample_position(input logic [DATA_W-1:0] roll, input logic [DATA_W-1:0] pick);
        send_item(MODE_SAMP_POS, IDX_W'($urandom), $urandom, $urandom, roll, pick);
    endtask

    task automatic sample_count(input logic [DATA_W-1:0] roll);
        send_item(MODE_SAMP_CNT, IDX_W'($urandom), $urandom, $urandom, roll, $urandom);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_record_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned       i;
        int unsigned       j;
        int unsigned       b;
        int unsigned       m;
        int unsigned       burst;
        int unsigned       sel;
        int unsigned       new_n;
        int unsigned       phase;
        int unsigned       span_lo;
        int unsigned       span_len;
        logic [DATA_W-1:0] mv;
        logic [DATA_W-1:0] pv;
        logic [DATA_W-1:0] map_step;
        logic [DATA_W-1:0] pos_step;
        logic [DATA_W-1:0] roll;
        logic [DATA_W-1:0] cdf_q [$];

        i_rst_n               = 1'b0;
        cfg_valid             = 1'b0;
        cfg_data              = '0;
        steady                = 1'b0;
        hold_seq              = 0;
        items_sent            = 0;
        item_ch.valid         = 1'b0;
        item_ch.mode          = MODE_LOAD_REC;
        item_ch.entry_index   = '0;
        item_ch.load_position = '0;
        item_ch.load_value    = '0;
        item_ch.roll          = '0;
        item_ch.pick          = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // low prefix, plus the records a full-depth search visits going all high or all low
        for (i = 0; i < LOAD_SPAN; i++) begin
            load_default(i);
        end
        span_lo  = 0;
        span_len = MAX_RECORDS;
        while (span_len > 0) begin
            j = span_lo + span_len / 2;
            load_default(j);
            span_lo  = j + 1;
            span_len = span_len - span_len / 2 - 1;
        end
        for (i = MAX_RECORDS / 4; i >= LOAD_SPAN; i = i / 2) begin
            load_default(i);
        end
        for (i = 0; i < COUNT_DEPTH; i++) begin
            if (i == COUNT_DEPTH - 1) begin
                load_count(i, 32'hFFFF_FFFF);
            end else begin
                load_count(i, DATA_W'(i) * 32'h1C71_C71C);
            end
        end

        // reset record count of two
        sample_position(32'h0000_0000, $urandom);
        sample_position(32'h0001_0001, 32'hFFFF_FFFF);
        sample_position(32'h0002_0000, 32'h0000_0000);
        sample_position(32'h0002_0001, $urandom);
        sample_position(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_count(32'h0000_0000);
        sample_count(32'h0000_0001);
        sample_count(32'hE38E_38E1);
        sample_count(32'hFFFF_FFFF);
        // out-of-range count loads must not land
        load_count(COUNT_DEPTH, 32'h0000_0000);
        load_count(MAX_RECORDS - 1, 32'h0000_0000);
        sample_count(32'h0000_0001);

        set_record_count(CFG_W'(0));
        sample_position(32'h0001_0000, $urandom);
        set_record_count(CFG_W'(1));
        sample_position(32'h0001_0000, $urandom);
        set_record_count(CFG_W'(4));
        sample_position(32'h0002_8000, $urandom);
        sample_position(32'h0003_1000, $urandom);
        sample_position(32'h0003_8000, $urandom);
        sample_position(32'h0003_8001, $urandom);
        set_record_count(CFG_W'(MAX_RECORDS));
        sample_position(32'hFFFF_FFFF, 32'h8000_0000);
        sample_position(32'h0012_3456, $urandom);
        set_record_count(CFG_W'(2047));
        sample_position(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_record_count(CFG_W'(MAX_RECORDS + 1));
        sample_position(32'h03FE_0001, $urandom);

        phase = 0;
        while (items_sent < ITEM_TARGET || phase < 5) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                new_n = $urandom_range(2, 16);
            end else if (sel < 55) begin
                new_n = LOAD_SPAN;
            end else if (sel < 70) begin
                new_n = $urandom_range(0, 3);
            end else begin
                new_n = $urandom_range(17, LOAD_SPAN - 1);
            end
            set_record_count(CFG_W'(new_n));
            m = (new_n < 2) ? 2 : new_n;

            if (phase == 0 || $urandom_range(0, 99) < 40) begin
                mv       = $urandom_range(0, 32'h000F_FFFF);
                pv       = $urandom_range(0, 32'h00FF_FFFF);
                map_step = 32'hE000_0000 / m;
                pos_step = 32'hE000_0000 / m;
                for (i = 0; i < m; i++) begin
                    load_record(i, pv, mv);
                    if ($urandom_range(0, 7) != 0) begin
                        mv = mv + $urandom_range(1, map_step);
                    end
                    sel = $urandom_range(0, 15);
                    if (sel == 0 && pv > 32'h1000) begin
                        pv = pv - $urandom_range(1, 32'h1000);
                    end else if (sel > 2) begin
                        pv = pv + $urandom_range(1, pos_step);
                    end
                end
            end

            if (phase == 0 || $urandom_range(0, 99) < 30) begin
                cdf_q.delete();
                for (i = 0; i < COUNT_DEPTH; i++) begin
                    cdf_q.insert(cdf_q.size(), $urandom);
                end
                cdf_q.sort();
                for (i = 1; i < COUNT_DEPTH; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        cdf_q[i] = cdf_q[i-1];
                    end
                end
                if ($urandom_range(0, 2) == 0) begin
                    cdf_q[COUNT_DEPTH-1] = 32'hFFFF_FFFF;
                end
                for (i = 0; i < COUNT_DEPTH; i++) begin
                    load_count(i, cdf_q[i]);
                end
            end

            if (phase == 2) begin
                hold_seq <= hold_seq + 1;
            end
            steady <= (phase == 4);

            burst = $urandom_range(20, 60);
            for (b = 0; b < burst; b++) begin
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    j = $urandom_range(0, m - 1);
                    case ($urandom_range(0, 3))
                        0: roll = map_shadow[j];
                        1: roll = map_shadow[j] + 32'd1;
                        2: begin
                            if (j == 0) begin
                                roll = map_shadow[0] - 32'd1;
                            end else begin
                                roll = $urandom_range(map_shadow[j-1], map_shadow[j]);
                            end
                        end
                        default: roll = $urandom;
                    endcase
                    sample_position(roll, $urandom);
                end else if (sel < 70) begin
                    j = $urandom_range(0, COUNT_DEPTH - 1);
                    case ($urandom_range(0, 3))
                        0:       roll = cnt_shadow[j];
                        1:       roll = cnt_shadow[j] + 32'd1;
                        2:       roll = cnt_shadow[j] - 32'd1;
                        default: roll = $urandom;
                    endcase
                    sample_count(roll);
                end else if (sel < 80) begin
                    if ($urandom_range(0, 1) == 0) begin
                        sample_position($urandom, $urandom);
                    end else begin
                        sample_count($urandom);
                    end
                end else if ($urandom_range(0, 1) == 0) begin
                    load_record($urandom_range(0, MAX_RECORDS - 1), $urandom, $urandom);
                end else if ($urandom_range(0, 3) == 0) begin
                    load_count($urandom_range(0, MAX_RECORDS - 1), $urandom);
                end else begin
                    load_count($urandom_range(0, COUNT_DEPTH - 1), $urandom);
                end
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/pcps_pkg.sv
design/pcps_if.sv
design/pcps_ram.sv
design/pcps_ctrl.sv
design/pcps_dp.sv
design/piecewise_cdf_position_sampler_unit.sv
verif/pcps_sample_checker.sv
verif/piecewise_cdf_position_sampler_unit_test.sv
